// ----- rtl/mos_pkg.sv -----
// Package for the median-of-set unit: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package mos_pkg;

    localparam int MAX_VALUES = 64;
    localparam int IDX_W      = $clog2(MAX_VALUES);
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);
    localparam int VAL_W      = 32;
    localparam int MED_W      = VAL_W + 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic issue_last;
        logic cmp_vld;
        logic out_full;
    } t_sts;

endpackage

// ----- rtl/mos_in_if.sv -----
// Input channel of the median-of-set unit: valid/ready plus one value item.
// Depends on mos_pkg for the value width.
interface mos_in_if;
    logic                      valid;
    logic                      ready;
    logic [mos_pkg::VAL_W-1:0] sample_value;
    logic                      last_value;

    modport source (output valid, output sample_value, output last_value, input ready);
    modport sink   (input valid, input sample_value, input last_value, output ready);
endinterface

// ----- rtl/mos_out_if.sv -----
// Output channel of the median-of-set unit: valid/ready plus one result item.
// Depends on mos_pkg for the result width.
interface mos_out_if;
    logic                      valid;
    logic                      ready;
    logic [mos_pkg::MED_W-1:0] median_doubled;
    logic                      too_many;

    modport source (output valid, output median_doubled, output too_many, input ready);
    modport sink   (input valid, input median_doubled, input too_many, output ready);
endinterface

// ----- rtl/mos_ctrl.sv -----
// Controller of the median-of-set unit: load, rank scan, drain, output.
// Depends on mos_pkg.
module mos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  logic          i_out_ready,
    input  mos_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output mos_pkg::t_cmd o_cmd
);

    mos_pkg::t_state r_state;
    mos_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mos_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mos_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = mos_pkg::S_SCAN;
                    end
                end
            end
            mos_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = mos_pkg::S_DRAIN;
                end
            end
            mos_pkg::S_DRAIN: begin
                // let the final compare settle the median registers
                n_state = mos_pkg::S_OUT;
            end
            mos_pkg::S_OUT: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mos_pkg::S_LOAD;
                end
            end
            default: n_state = mos_pkg::S_LOAD;
        endcase
    end

endmodule

// ----- rtl/mos_dp.sv -----
// Datapath of the median-of-set unit: value store, rank-count scan and
// output register. Depends on mos_pkg.
module mos_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mos_pkg::t_cmd             i_cmd,
    output mos_pkg::t_sts             o_sts,
    input  logic [mos_pkg::VAL_W-1:0] i_sample_value,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [mos_pkg::MED_W-1:0] o_median_doubled,
    output logic                      o_too_many
);

    logic [mos_pkg::VAL_W-1:0] mem [mos_pkg::MAX_VALUES];

    logic [mos_pkg::CNT_W-1:0] r_count;
    logic                      r_ovf;
    logic [mos_pkg::CNT_W-1:0] r_n;
    logic                      r_set_ovf;
    logic [mos_pkg::IDX_W-1:0] r_i;
    logic [mos_pkg::IDX_W-1:0] r_j;
    logic [mos_pkg::VAL_W-1:0] r_rd_a;
    logic [mos_pkg::VAL_W-1:0] r_rd_b;
    logic                      r_cmp_vld;
    logic                      r_cmp_last;
    logic [mos_pkg::CNT_W-1:0] r_lt;
    logic [mos_pkg::CNT_W-1:0] r_le;
    logic [mos_pkg::VAL_W-1:0] r_hi;
    logic [mos_pkg::VAL_W-1:0] r_lo;
    logic                      r_out_vld;
    logic [mos_pkg::MED_W-1:0] r_med_out;
    logic                      r_ovf_out;

    logic                      w_store_ok;
    logic [mos_pkg::CNT_W-1:0] w_count_inc;
    logic [mos_pkg::CNT_W-1:0] w_n_m1;
    logic                      w_j_end;
    logic [mos_pkg::CNT_W-1:0] w_lt_next;
    logic [mos_pkg::CNT_W-1:0] w_le_next;
    logic [mos_pkg::CNT_W-1:0] w_mid;
    logic [mos_pkg::CNT_W-1:0] w_k_lo;
    logic                      w_hit_hi;
    logic                      w_hit_lo;

    assign w_store_ok  = r_count < mos_pkg::CNT_W'(mos_pkg::MAX_VALUES);
    assign w_count_inc = r_count + 1'b1;
    assign w_n_m1      = r_n - 1'b1;
    assign w_j_end     = r_j == w_n_m1[mos_pkg::IDX_W-1:0];

    // rank of candidate: values below it and values not above it
    assign w_lt_next = r_lt + mos_pkg::CNT_W'(r_rd_b <  r_rd_a);
    assign w_le_next = r_le + mos_pkg::CNT_W'(r_rd_b <= r_rd_a);
    assign w_mid     = r_n >> 1;
    assign w_k_lo    = r_n[0] ? w_mid : (w_mid - 1'b1);
    assign w_hit_hi  = (w_lt_next <= w_mid)  && (w_mid  < w_le_next);
    assign w_hit_lo  = (w_lt_next <= w_k_lo) && (w_k_lo < w_le_next);

    assign o_sts.issue_last = (r_i == w_n_m1[mos_pkg::IDX_W-1:0]) && w_j_end;
    assign o_sts.cmp_vld    = r_cmp_vld;
    assign o_sts.out_full   = r_out_vld;

    assign o_out_valid      = r_out_vld;
    assign o_median_doubled = r_med_out;
    assign o_too_many       = r_ovf_out;

    // store with one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_store_ok) begin
            mem[r_count[mos_pkg::IDX_W-1:0]] <= i_sample_value;
        end
        r_rd_a <= mem[r_i];
        r_rd_b <= mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_cmp_last <= 1'b0;
            r_lt       <= '0;
            r_le       <= '0;
            r_out_vld  <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_cmd.scan_start) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (w_store_ok) begin
                    r_count <= w_count_inc;
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.scan_start) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.scan_step) begin
                if (w_j_end) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end

            r_cmp_vld  <= i_cmd.scan_step;
            r_cmp_last <= i_cmd.scan_step && w_j_end;

            if (i_cmd.scan_start) begin
                r_lt <= '0;
                r_le <= '0;
            end else if (r_cmp_vld) begin
                if (r_cmp_last) begin
                    r_lt <= '0;
                    r_le <= '0;
                end else begin
                    r_lt <= w_lt_next;
                    r_le <= w_le_next;
                end
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_n       <= w_store_ok ? w_count_inc : r_count;
            r_set_ovf <= r_ovf || !w_store_ok;
            r_hi      <= '0;
            r_lo      <= '0;
        end else if (r_cmp_vld && r_cmp_last) begin
            if (w_hit_hi) begin
                r_hi <= r_rd_a;
            end
            if (w_hit_lo) begin
                r_lo <= r_rd_a;
            end
        end
        if (i_cmd.out_load) begin
            r_med_out <= {1'b0, r_hi} + {1'b0, r_lo};
            r_ovf_out <= r_set_ovf;
        end
    end

endmodule

// ----- rtl/median_of_set_unit.sv -----
// Top level of the median-of-set unit: controller plus datapath.
// Depends on mos_pkg, mos_in_if, mos_out_if, mos_ctrl and mos_dp.

// Values of a set arrive one item per cycle while the unit loads, and are
// written into a 64-entry store; an item marked last closes the set. Values
// beyond 64 are dropped and flagged in too_many. After the last item the
// unit finds the median by rank counting: each stored value in turn is
// compared against every stored value, one compare per cycle on the store's
// second read port; drain and output hand-off follow the scan before the
// next set is taken. median_doubled is twice the median (one fraction bit):
// twice the middle value for an odd count, the exact 33-bit sum of the two
// middle values for an even count. The result sits in an output register,
// so a stalled sink holds it while the next set loads; the unit waits only
// if a new result is ready before the old one is taken.
module median_of_set_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mos_in_if.sink    i_item,
    mos_out_if.source o_result
);

    mos_pkg::t_cmd w_cmd;
    mos_pkg::t_sts w_sts;

    // sequence load, scan, drain and output hand-off
    mos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_last   (i_item.last_value),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_item.ready),
        .o_cmd       (w_cmd)
    );

    // hold the store, count ranks and register the result
    mos_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample_value   (i_item.sample_value),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_median_doubled (o_result.median_doubled),
        .o_too_many       (o_result.too_many)
    );

    // a new result never overwrites one the sink has not taken
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!w_sts.out_full || o_result.ready))
        else $error("result register overwritten");

    // no compare is in flight while items are being taken
    a_no_cmp_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !w_sts.cmp_vld)
        else $error("compare active during load");

    // the scan's last issue is followed by its final compare
    a_scan_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan_step && w_sts.issue_last) |=> (w_sts.cmp_vld && !i_item.ready))
        else $error("scan did not drain");

endmodule
